@@ hdl/fspa_pkg.sv @@
package fspa_pkg;

    // pool geometry
    localparam int POOL_COUNT = 2;
    localparam int MAX_SLOTS  = 32;
    localparam int TAG_BYTES  = 8;
    localparam longint unsigned MEMORY_BYTES = 64'd67108864;

    // field widths
    localparam int REQ_W     = 24;
    localparam int REL_W     = 32;
    localparam int OFF_W     = 26;
    localparam int CFG_CNT_W = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    // derived widths
    localparam int POOL_W = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam longint unsigned SPAN_MAX =
        longint'(POOL_COUNT) * longint'(MAX_SLOTS) * (longint'(TAG_BYTES) + 64'd16777216);
    localparam int ACC_W  = $clog2(SPAN_MAX) + 1;

    // register reset values
    localparam int CNT0_RESET   = 20;
    localparam int BYTES0_RESET = 230400;
    localparam int CNT1_RESET   = 1;
    localparam int BYTES1_RESET = 4096;

    // low bit of a register index selects the field of a pool
    localparam logic CFG_FIELD_COUNT = 1'b0;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC_OK  = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_FREED     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POOL_INIT,
        S_SLOT,
        S_POOL_NEXT
    } t_state;

    typedef struct packed {
        logic    load;
        logic    pool_init;
        logic    slot_step;
        logic    pool_next;
        logic    set_busy;
        logic    clr_busy;
        logic    finish;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic in_free;
        logic in_oor;
        logic is_free;
        logic slot_end;
        logic fits;
        logic size_match;
        logic busy_bit;
        logic off_match;
        logic pool_last;
    } t_sts;

    function automatic logic [CFG_CNT_W-1:0] cnt_reset(input int p);
        if (p == 0) begin
            return CFG_CNT_W'(CNT0_RESET);
        end else if (p == 1) begin
            return CFG_CNT_W'(CNT1_RESET);
        end
        return '0;
    endfunction

    function automatic logic [REQ_W-1:0] bytes_reset(input int p);
        if (p == 0) begin
            return REQ_W'(BYTES0_RESET);
        end else if (p == 1) begin
            return REQ_W'(BYTES1_RESET);
        end
        return '0;
    endfunction

endpackage

@@ hdl/fixed_slot_pool_allocator_core.sv @@
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+-------------------------------
// request   | i_kind, i_request_bytes, i_release_offset    | start high while busy low
// result    | o_buffer_offset, o_status                    | o_done high for one cycle
// config    | i_cfg_idx, i_cfg_data                        | i_cfg_we high, no wait
//
// a free beyond memory is answered from idle without a walk; otherwise the item is
// accepted, then each pool passes an init step, its slot walk and a next-pool step,
// and the item ends in the slot walk of the pool that answers or after the last
// pool; the slot walk is one slot per cycle through a single offset adder
// one item at a time: busy stays high until the cycle before the result shows
// the next item may start in the cycle o_done is high
// synchronous active-low reset clears the busy map and restores the configuration registers
module fixed_slot_pool_allocator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_kind,
    input  logic [fspa_pkg::REQ_W-1:0]      i_request_bytes,
    input  logic [fspa_pkg::REL_W-1:0]      i_release_offset,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [fspa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fspa_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // result channel
    output logic                            o_done,
    output logic [fspa_pkg::OFF_W-1:0]      o_buffer_offset,
    output logic [1:0]                      o_status
);

    // command and status between sequencer and datapath
    fspa_pkg::t_cmd cmd;
    fspa_pkg::t_sts sts;

    // sequencer: walks pools in order, slots in order within a pool
    fspa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: registers, busy map, running offset and the result register
    fspa_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (i_kind),
        .i_request_bytes  (i_request_bytes),
        .i_release_offset (i_release_offset),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_done           (o_done),
        .o_buffer_offset  (o_buffer_offset),
        .o_status         (o_status)
    );

endmodule

@@ hdl/fspa_ctrl.sv @@
module fspa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  fspa_pkg::t_sts  i_sts,
    output fspa_pkg::t_cmd  o_cmd
);

    fspa_pkg::t_state r_state;
    fspa_pkg::t_state n_state;
    logic             pool_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fspa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a pool ends at its slot count, at the first buffer past memory,
    // or at once for an allocate of another size
    assign pool_end = i_sts.slot_end || !i_sts.fits ||
                      (!i_sts.is_free && !i_sts.size_match);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = fspa_pkg::ST_ALLOC_OK;
        case (r_state)
            fspa_pkg::S_IDLE: begin
                if (start) begin
                    if (i_sts.in_free && i_sts.in_oor) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = fspa_pkg::ST_NOT_FOUND;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = fspa_pkg::S_POOL_INIT;
                    end
                end
            end
            fspa_pkg::S_POOL_INIT: begin
                o_cmd.pool_init = 1'b1;
                n_state         = fspa_pkg::S_SLOT;
            end
            fspa_pkg::S_SLOT: begin
                if (pool_end) begin
                    n_state = fspa_pkg::S_POOL_NEXT;
                end else if (!i_sts.is_free && !i_sts.busy_bit) begin
                    o_cmd.set_busy = 1'b1;
                    o_cmd.finish   = 1'b1;
                    o_cmd.status   = fspa_pkg::ST_ALLOC_OK;
                    n_state        = fspa_pkg::S_IDLE;
                end else if (i_sts.is_free && i_sts.busy_bit && i_sts.off_match) begin
                    o_cmd.clr_busy = 1'b1;
                    o_cmd.finish   = 1'b1;
                    o_cmd.status   = fspa_pkg::ST_FREED;
                    n_state        = fspa_pkg::S_IDLE;
                end else begin
                    o_cmd.slot_step = 1'b1;
                end
            end
            fspa_pkg::S_POOL_NEXT: begin
                if (i_sts.pool_last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = i_sts.is_free ? fspa_pkg::ST_NOT_FOUND
                                                 : fspa_pkg::ST_NO_SLOT;
                    n_state      = fspa_pkg::S_IDLE;
                end else begin
                    o_cmd.pool_next = 1'b1;
                    n_state         = fspa_pkg::S_POOL_INIT;
                end
            end
            default: begin
                n_state = fspa_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != fspa_pkg::S_IDLE);

endmodule

@@ hdl/fspa_datapath.sv @@
module fspa_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_kind,
    input  logic [fspa_pkg::REQ_W-1:0]      i_request_bytes,
    input  logic [fspa_pkg::REL_W-1:0]      i_release_offset,
    input  logic                            i_cfg_we,
    input  logic [fspa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fspa_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  fspa_pkg::t_cmd                  i_cmd,
    output fspa_pkg::t_sts                  o_sts,
    output logic                            o_done,
    output logic [fspa_pkg::OFF_W-1:0]      o_buffer_offset,
    output logic [1:0]                      o_status
);

    // configuration
    logic [fspa_pkg::CFG_CNT_W-1:0] r_cnt   [fspa_pkg::POOL_COUNT];
    logic [fspa_pkg::REQ_W-1:0]     r_bytes [fspa_pkg::POOL_COUNT];

    // request and walk state
    logic                           r_kind;
    logic [fspa_pkg::REQ_W-1:0]     r_req;
    logic [fspa_pkg::REL_W-1:0]     r_rel;
    logic [fspa_pkg::POOL_W-1:0]    r_pool;
    logic [fspa_pkg::CNT_W-1:0]     r_slot;
    logic [fspa_pkg::ACC_W-1:0]     r_area;
    logic [fspa_pkg::ACC_W-1:0]     r_base;
    logic [fspa_pkg::ACC_W-1:0]     r_prod;
    logic [fspa_pkg::ACC_W-1:0]     r_off;

    logic [fspa_pkg::POOL_COUNT-1:0][fspa_pkg::MAX_SLOTS-1:0] r_busy;

    logic                           r_done;
    logic [fspa_pkg::OFF_W-1:0]     r_offset;
    logic [1:0]                     r_status;

    logic [fspa_pkg::CFG_CNT_W-1:0] cur_cnt;
    logic [fspa_pkg::REQ_W-1:0]     cur_bytes;
    logic [fspa_pkg::CNT_W-1:0]     cnt_eff;
    logic [fspa_pkg::ACC_W-1:0]     buf_base;
    logic [fspa_pkg::SLOT_W-1:0]    slot_idx;
    logic [fspa_pkg::POOL_W-1:0]    cfg_pool;

    assign cur_cnt   = r_cnt[r_pool];
    assign cur_bytes = r_bytes[r_pool];
    assign cnt_eff   = (int'(cur_cnt) > fspa_pkg::MAX_SLOTS)
                     ? fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS)
                     : fspa_pkg::CNT_W'(cur_cnt);
    assign buf_base  = r_area + fspa_pkg::ACC_W'(cnt_eff)
                              * fspa_pkg::ACC_W'(fspa_pkg::TAG_BYTES);
    assign slot_idx  = r_slot[fspa_pkg::SLOT_W-1:0];
    assign cfg_pool  = fspa_pkg::POOL_W'(i_cfg_idx[fspa_pkg::CFG_IDX_W-1:1]);

    always_comb begin
        o_sts            = '0;
        o_sts.in_free    = (i_kind == fspa_pkg::KIND_FREE);
        o_sts.in_oor     = {1'b0, i_release_offset}
                           >= (fspa_pkg::REL_W + 1)'(fspa_pkg::MEMORY_BYTES);
        o_sts.is_free    = (r_kind == fspa_pkg::KIND_FREE);
        o_sts.slot_end   = (r_slot >= cnt_eff);
        o_sts.fits       = ((fspa_pkg::ACC_W + 1)'(r_off) + (fspa_pkg::ACC_W + 1)'(cur_bytes))
                           <= (fspa_pkg::ACC_W + 1)'(fspa_pkg::MEMORY_BYTES);
        o_sts.size_match = (cur_bytes == r_req);
        o_sts.busy_bit   = r_busy[r_pool][slot_idx];
        o_sts.off_match  = (64'(r_off) == 64'(r_rel));
        o_sts.pool_last  = (int'(r_pool) == fspa_pkg::POOL_COUNT - 1);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < fspa_pkg::POOL_COUNT; p++) begin
                r_cnt[p]   <= fspa_pkg::cnt_reset(p);
                r_bytes[p] <= fspa_pkg::bytes_reset(p);
            end
        end else if (i_cfg_we && (int'(i_cfg_idx[fspa_pkg::CFG_IDX_W-1:1])
                                  < fspa_pkg::POOL_COUNT)) begin
            if (i_cfg_idx[0] == fspa_pkg::CFG_FIELD_COUNT) begin
                r_cnt[cfg_pool] <= i_cfg_data[fspa_pkg::CFG_CNT_W-1:0];
            end else begin
                r_bytes[cfg_pool] <= i_cfg_data[fspa_pkg::REQ_W-1:0];
            end
        end
    end

    // busy map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_cmd.set_busy) begin
            r_busy[r_pool][slot_idx] <= 1'b1;
        end else if (i_cmd.clr_busy) begin
            r_busy[r_pool][slot_idx] <= 1'b0;
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_req  <= i_request_bytes;
            r_rel  <= i_release_offset;
            r_area <= '0;
            r_pool <= '0;
        end
        if (i_cmd.pool_init) begin
            r_prod <= fspa_pkg::ACC_W'(cnt_eff) * fspa_pkg::ACC_W'(cur_bytes);
            r_base <= buf_base;
            r_off  <= buf_base;
            r_slot <= '0;
        end
        if (i_cmd.slot_step) begin
            r_off  <= r_off + fspa_pkg::ACC_W'(cur_bytes);
            r_slot <= r_slot + 1'b1;
        end
        if (i_cmd.pool_next) begin
            r_area <= r_base + r_prod;
            r_pool <= r_pool + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
            r_offset <= (i_cmd.status == fspa_pkg::ST_ALLOC_OK)
                      ? r_off[fspa_pkg::OFF_W-1:0] : '0;
        end
    end

    assign o_done          = r_done;
    assign o_buffer_offset = r_offset;
    assign o_status        = r_status;

endmodule

@@ hdl/fspa_checker.sv @@
module fspa_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic                            i_kind,
    input  logic [fspa_pkg::REL_W-1:0]      i_release_offset,
    input  logic                            o_done,
    input  logic [fspa_pkg::OFF_W-1:0]      o_buffer_offset,
    input  logic [1:0]                      o_status
);

    // the walk has finished when its result shows
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    // a result only after an accepted item or a walk
    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(busy) || $past(start)))
        else $error("result without an item");

    // failures carry a zero offset
    a_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != fspa_pkg::ST_ALLOC_OK) |-> (o_buffer_offset == '0))
        else $error("nonzero offset on a failed item");

    // a free beyond memory is answered at once
    a_oor_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_kind == fspa_pkg::KIND_FREE &&
         {1'b0, i_release_offset} >= (fspa_pkg::REL_W + 1)'(fspa_pkg::MEMORY_BYTES))
        |=> (o_done && o_status == fspa_pkg::ST_NOT_FOUND))
        else $error("free beyond memory not rejected");

endmodule

bind fixed_slot_pool_allocator_core fspa_checker u_fspa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_kind           (i_kind),
    .i_release_offset (i_release_offset),
    .o_done           (o_done),
    .o_buffer_offset  (o_buffer_offset),
    .o_status         (o_status)
);
